@@ hw/rtl/rptw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptw_pkg
// shared types and constants of the ping rtt window tracker
// ----------------------------------------------------------------------------
package rptw_pkg;

    localparam logic [1:0] OP_PING = 2'd0;
    localparam logic [1:0] OP_PONG = 2'd1;
    localparam logic [1:0] OP_BW   = 2'd2;

    localparam logic [1:0] KIND_PING = 2'd0;
    localparam logic [1:0] KIND_RTT  = 2'd1;
    localparam logic [1:0] KIND_RPT  = 2'd2;

    localparam logic CFG_WINDOW   = 1'b0;
    localparam logic CFG_INTERVAL = 1'b1;

    localparam int          TIME_W      = 48;
    localparam int          SEQ_W       = 16;
    localparam int          RTT_W       = 32;
    localparam int          MS_W        = 23;
    localparam int          WIN_W       = 24;
    localparam int          INTV_W      = 26;
    localparam int          DIVISOR_W   = 32;
    localparam logic [23:0] WIN_RESET   = 24'd500000;
    localparam logic [25:0] INTV_RESET  = 26'd1000000;

    // divide by 1000 as multiply by ceil(2^38 / 1000), exact for 32-bit inputs
    localparam int          MS_RECIP_W  = 29;
    localparam int          MS_SHIFT    = 38;
    localparam logic [28:0] MS_RECIP    = 29'd274877907;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hw/rtl/rptw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptw_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/rptw_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rptw_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rptw_div #(
    parameter int NUM_W = 39
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [NUM_W-1:0]                     i_dividend,
    input  logic [rptw_pkg::DIVISOR_W-1:0]       i_divisor,
    output logic [NUM_W-1:0]                     o_quotient,
    output rptw_pkg::t_div_stat                  o_stat
);
    import rptw_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DIVISOR_W-1:0] r_dvs;
    logic [DIVISOR_W:0]   r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign trial = {r_rem[DIVISOR_W-1:0], r_quo[NUM_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? trial - {1'b0, r_dvs} : trial;
                r_quo <= {r_quo[NUM_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ hw/rtl/ping_rtt_window_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ping_rtt_window_tracker_top
// ping sequence allocation, rtt window statistics and bandwidth reports
// ----------------------------------------------------------------------------
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser op, tdata now/seq/ms/bytes
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tuser kind, tdata results, tlast
// cfg      | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one request is worked at a time; s_axis_tready is high only while idle
// ping: one pending scan per candidate number, then the queue write and the result
// pong: pending scan + expiry of each dropped sample + sample scan
//   + one division for the mean + ms conversion of base and mean
// bandwidth: one division, then the same window path
// a report adds a free number search like a ping
// results sit in an output register; while m_axis stalls, the next result waits in its emit state
// synchronous active-low reset, no memory clearing pass (counts cover the rams)
// ----------------------------------------------------------------------------
module ping_rtt_window_tracker_top #(
    parameter int PENDING_DEPTH = 64,
    parameter int SAMPLE_DEPTH  = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request input
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // now_us, pong_sequence, elapsed_ms, bytes_seen
    input  logic [1:0]    s_axis_tuser,  // operation
    // result output
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [159:0]  m_axis_tdata,  // sequence_out, base_rtt_us, avg_rtt_us,
                                         // bandwidth_kbps, base_rtt_ms, avg_rtt_ms, pad
    output logic [1:0]    m_axis_tuser,  // kind
    output logic          m_axis_tlast,  // last
    // configuration
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_index,
    input  logic [25:0]   i_cfg_data
);
    import rptw_pkg::*;

    localparam int PAW   = $clog2(PENDING_DEPTH);
    localparam int PCW   = $clog2(PENDING_DEPTH + 1);
    localparam int SAW   = $clog2(SAMPLE_DEPTH);
    localparam int SCW   = $clog2(SAMPLE_DEPTH + 1);
    localparam int IW    = (PCW > SCW) ? PCW : SCW;
    localparam int SUMW  = RTT_W + SCW;
    localparam int NUM_W = (SUMW > 35) ? SUMW : 35;
    localparam int PW    = TIME_W + SEQ_W;
    localparam int SW    = TIME_W + RTT_W;
    localparam int MPW   = RTT_W + MS_RECIP_W;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SEQ_CHK  = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_PING_WR  = 4'd3;
    localparam logic [3:0] S_EMIT_PNG = 4'd4;
    localparam logic [3:0] S_PONG_UPD = 4'd5;
    localparam logic [3:0] S_SMP_WR   = 4'd6;
    localparam logic [3:0] S_EXP_RD   = 4'd7;
    localparam logic [3:0] S_EXP_CHK  = 4'd8;
    localparam logic [3:0] S_SUM      = 4'd9;
    localparam logic [3:0] S_DIV      = 4'd10;
    localparam logic [3:0] S_GATE     = 4'd11;
    localparam logic [3:0] S_EMIT_RTT = 4'd12;
    localparam logic [3:0] S_EMIT_RPT = 4'd13;
    localparam logic [3:0] S_MS_BASE  = 4'd14;
    localparam logic [3:0] S_MS_AVG   = 4'd15;

    // divider jobs
    localparam logic [1:0] D_BW  = 2'd0;
    localparam logic [1:0] D_AVG = 2'd1;

    function automatic logic [PAW-1:0] pwrap(input logic [PAW:0] s);
        logic [PAW:0] r;
        r = (s >= (PAW+1)'(PENDING_DEPTH)) ? s - (PAW+1)'(PENDING_DEPTH) : s;
        return r[PAW-1:0];
    endfunction

    function automatic logic [SAW-1:0] swrap(input logic [SAW:0] s);
        logic [SAW:0] r;
        r = (s >= (SAW+1)'(SAMPLE_DEPTH)) ? s - (SAW+1)'(SAMPLE_DEPTH) : s;
        return r[SAW-1:0];
    endfunction

    logic [3:0]          r_state;
    // latched request
    logic [TIME_W-1:0]   r_now;
    logic                r_is_pong;
    // tracker state
    logic [PAW-1:0]      r_phead;
    logic [PCW-1:0]      r_pcnt;
    logic [SAW-1:0]      r_shead;
    logic [SCW-1:0]      r_scnt;
    logic [SEQ_W-1:0]    r_next_seq;
    logic [31:0]         r_bw;
    logic [TIME_W-1:0]   r_last_rpt;
    logic [WIN_W-1:0]    r_win;
    logic [INTV_W-1:0]   r_intv;
    // scan and working registers
    logic [IW-1:0]       r_i;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic [SEQ_W-1:0]    r_key;
    logic                r_for_rpt;
    logic                r_scan_pong;
    logic [PAW-1:0]      r_k;
    logic [TIME_W-1:0]   r_ptime;
    logic [RTT_W-1:0]    r_rtt;
    logic [SUMW-1:0]     r_sum;
    logic [RTT_W-1:0]    r_min;
    logic [RTT_W-1:0]    r_base;
    logic [RTT_W-1:0]    r_avg;
    logic [MS_W-1:0]     r_bms;
    logic [MS_W-1:0]     r_ams;
    logic                r_gate;
    logic [1:0]          r_div_sel;
    logic                r_div_go;
    logic [NUM_W-1:0]    r_dvd;
    logic [31:0]         r_dvs;
    // output register
    logic                r_ovalid;
    logic [1:0]          r_okind;
    logic [SEQ_W-1:0]    r_oseq;
    logic [RTT_W-1:0]    r_obase;
    logic [RTT_W-1:0]    r_oavg;
    logic [31:0]         r_obw;
    logic [MS_W-1:0]     r_obms;
    logic [MS_W-1:0]     r_oams;
    logic                r_olast;

    // memories
    logic                p_we;
    logic [PAW-1:0]      p_waddr;
    logic [PAW-1:0]      p_raddr;
    logic [PW-1:0]       p_rdata;
    logic                s_we;
    logic [SAW-1:0]      s_waddr;
    logic [SAW-1:0]      s_raddr;
    logic [SW-1:0]       s_rdata;

    logic [NUM_W-1:0]    div_q;
    t_div_stat           div_stat;

    logic                in_acc;
    logic                ofree;
    logic                scan_issue;
    logic                scan_hit;
    logic                sum_issue;
    logic [TIME_W-1:0]   pong_diff;
    logic [RTT_W-1:0]    rtt_sat;
    logic [TIME_W-1:0]   smp_time;
    logic                expire;
    logic [TIME_W-1:0]   rpt_age;
    logic                gate;
    logic [31:0]         bw_sat;
    logic [RTT_W-1:0]    ms_src;
    logic [MPW-1:0]      ms_prod;
    logic [MS_W-1:0]     ms_val;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign ofree         = !r_ovalid || m_axis_tready;

    // pending queue is a ring: head plus count
    assign p_we    = (r_state == S_PING_WR);
    assign p_waddr = pwrap({1'b0, r_phead} + {1'b0, r_pcnt[PAW-1:0]});
    assign p_raddr = pwrap({1'b0, r_phead} + {1'b0, r_i[PAW-1:0]});

    // sample window ring: entries hold {time, rtt}
    assign s_we    = (r_state == S_SMP_WR);
    assign s_waddr = swrap({1'b0, r_shead} + {1'b0, r_scnt[SAW-1:0]});
    assign s_raddr = (r_state == S_SUM) ? swrap({1'b0, r_shead} + {1'b0, r_i[SAW-1:0]})
                                        : r_shead;

    rptw_ram #(.WIDTH(PW), .DEPTH(PENDING_DEPTH)) u_pend_ram (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata({r_now, r_key}),
        .i_raddr(p_raddr),
        .o_rdata(p_rdata)
    );

    rptw_ram #(.WIDTH(SW), .DEPTH(SAMPLE_DEPTH)) u_smp_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata({r_now, r_rtt}),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    rptw_div #(.NUM_W(NUM_W)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_go),
        .i_dividend(r_dvd),
        .i_divisor (r_dvs),
        .o_quotient(div_q),
        .o_stat    (div_stat)
    );

    // pipelined scan of the pending queue: address out, compare in the following cycle
    assign scan_issue = (IW'(r_pcnt) > r_i);
    assign scan_hit   = r_pv && (p_rdata[SEQ_W-1:0] == r_key);
    assign sum_issue  = (IW'(r_scnt) > r_i);

    // rtt of the matched ping, clamped at zero and saturated to 32 bits
    assign pong_diff = (r_now >= r_ptime) ? r_now - r_ptime : '0;
    assign rtt_sat   = (|pong_diff[TIME_W-1:RTT_W]) ? '1 : pong_diff[RTT_W-1:0];

    // a sample with a time ahead of now never expires
    assign smp_time = s_rdata[SW-1:RTT_W];
    assign expire   = (r_now >= smp_time) &&
                      ((r_now - smp_time) >= TIME_W'(r_win));

    // report gate: rate limit, nonzero bandwidth and a non-empty window
    assign rpt_age = r_now - r_last_rpt;
    assign gate    = (r_bw != '0) && (r_scnt != '0) && (r_now >= r_last_rpt) &&
                     (rpt_age >= TIME_W'(r_intv));

    assign bw_sat = (|div_q[NUM_W-1:32]) ? '1 : div_q[31:0];

    // microseconds to milliseconds, one shared reciprocal multiplier
    assign ms_src  = (r_state == S_MS_BASE) ? r_base : r_avg;
    assign ms_prod = {{MS_RECIP_W{1'b0}}, ms_src} * {{RTT_W{1'b0}}, MS_RECIP};
    assign ms_val  = ms_prod[MS_SHIFT+MS_W-1:MS_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pcnt     <= '0;
            r_phead    <= '0;
            r_scnt     <= '0;
            r_shead    <= '0;
            r_next_seq <= '0;
            r_bw       <= '0;
            r_last_rpt <= '0;
            r_win      <= WIN_RESET;
            r_intv     <= INTV_RESET;
            r_ovalid   <= 1'b0;
            r_div_go   <= 1'b0;
            r_pv       <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WINDOW:   r_win  <= i_cfg_data[WIN_W-1:0];
                    CFG_INTERVAL: r_intv <= i_cfg_data;
                    default:      r_win  <= r_win;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_now     <= s_axis_tdata[47:0];
                        r_is_pong <= (s_axis_tuser == OP_PONG);
                        case (s_axis_tuser)
                            OP_PING: begin
                                // a full queue is emptied before allocation
                                if (r_pcnt >= PCW'(PENDING_DEPTH)) begin
                                    r_pcnt <= '0;
                                end
                                r_key       <= r_next_seq;
                                r_for_rpt   <= 1'b0;
                                r_scan_pong <= 1'b0;
                                r_state     <= S_SEQ_CHK;
                            end
                            OP_PONG: begin
                                r_key       <= s_axis_tdata[63:48];
                                r_scan_pong <= 1'b1;
                                r_i         <= '0;
                                r_pv        <= 1'b0;
                                r_state     <= S_SCAN;
                            end
                            OP_BW: begin
                                r_dvd     <= NUM_W'({s_axis_tdata[127:96], 3'b000});
                                r_dvs     <= (s_axis_tdata[95:64] == '0) ? 32'd1
                                                                         : s_axis_tdata[95:64];
                                r_div_sel <= D_BW;
                                r_div_go  <= 1'b1;
                                r_state   <= S_DIV;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end

                // candidate number: skip zero, otherwise look it up
                S_SEQ_CHK: begin
                    if (r_key == '0) begin
                        r_key <= SEQ_W'(1);
                    end else begin
                        r_i     <= '0;
                        r_pv    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end

                S_SCAN: begin
                    r_pv   <= scan_issue;
                    r_pidx <= r_i;
                    if (scan_issue) begin
                        r_i <= r_i + 1'b1;
                    end
                    if (scan_hit) begin
                        r_pv <= 1'b0;
                        if (r_scan_pong) begin
                            r_k     <= r_pidx[PAW-1:0];
                            r_ptime <= p_rdata[PW-1:SEQ_W];
                            r_state <= S_PONG_UPD;
                        end else begin
                            r_key   <= r_key + 1'b1;
                            r_state <= S_SEQ_CHK;
                        end
                    end else if (!scan_issue && !r_pv) begin
                        if (r_scan_pong) begin
                            r_state <= S_IDLE;
                        end else if (r_for_rpt) begin
                            r_state <= S_EMIT_RPT;
                        end else begin
                            r_state <= S_PING_WR;
                        end
                    end
                end

                S_PING_WR: begin
                    r_pcnt     <= r_pcnt + 1'b1;
                    r_next_seq <= r_key + 1'b1;
                    r_state    <= S_EMIT_PNG;
                end

                S_EMIT_PNG: begin
                    if (ofree) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_PING;
                        r_oseq   <= r_key;
                        r_obase  <= '0;
                        r_oavg   <= '0;
                        r_obw    <= '0;
                        r_obms   <= '0;
                        r_oams   <= '0;
                        r_olast  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end

                // drop the matched ping and every older one; a full sample window loses its oldest entry
                S_PONG_UPD: begin
                    r_phead <= pwrap({1'b0, r_phead} + {1'b0, r_k} + (PAW+1)'(1));
                    r_pcnt  <= r_pcnt - PCW'(r_k) - PCW'(1);
                    r_rtt   <= rtt_sat;
                    if (r_scnt >= SCW'(SAMPLE_DEPTH)) begin
                        r_shead <= swrap({1'b0, r_shead} + (SAW+1)'(1));
                        r_scnt  <= r_scnt - 1'b1;
                    end
                    r_state <= S_SMP_WR;
                end

                S_SMP_WR: begin
                    r_scnt  <= r_scnt + 1'b1;
                    r_state <= S_EXP_RD;
                end

                S_EXP_RD: begin
                    if (r_scnt == '0) begin
                        // empty window: base and mean are zero
                        r_base  <= '0;
                        r_avg   <= '0;
                        r_state <= S_MS_BASE;
                    end else begin
                        r_state <= S_EXP_CHK;
                    end
                end

                S_EXP_CHK: begin
                    if (expire) begin
                        r_shead <= swrap({1'b0, r_shead} + (SAW+1)'(1));
                        r_scnt  <= r_scnt - 1'b1;
                        r_state <= S_EXP_RD;
                    end else begin
                        r_i     <= '0;
                        r_pv    <= 1'b0;
                        r_sum   <= '0;
                        r_min   <= '1;
                        r_state <= S_SUM;
                    end
                end

                // sum and minimum over the window, one sample a cycle
                S_SUM: begin
                    r_pv <= sum_issue;
                    if (sum_issue) begin
                        r_i <= r_i + 1'b1;
                    end
                    if (r_pv) begin
                        r_sum <= r_sum + SUMW'(s_rdata[RTT_W-1:0]);
                        if (s_rdata[RTT_W-1:0] < r_min) begin
                            r_min <= s_rdata[RTT_W-1:0];
                        end
                    end else if (!sum_issue) begin
                        r_base    <= r_min;
                        r_dvd     <= NUM_W'(r_sum);
                        r_dvs     <= 32'(r_scnt);
                        r_div_sel <= D_AVG;
                        r_div_go  <= 1'b1;
                        r_state   <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (div_stat.done) begin
                        case (r_div_sel)
                            D_BW: begin
                                r_bw    <= bw_sat;
                                r_state <= S_EXP_RD;
                            end
                            D_AVG: begin
                                r_avg   <= div_q[RTT_W-1:0];
                                r_state <= S_MS_BASE;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end

                S_MS_BASE: begin
                    r_bms   <= ms_val;
                    r_state <= S_MS_AVG;
                end

                S_MS_AVG: begin
                    r_ams   <= ms_val;
                    r_state <= S_GATE;
                end

                S_GATE: begin
                    r_gate <= gate;
                    if (r_is_pong) begin
                        r_state <= S_EMIT_RTT;
                    end else if (gate) begin
                        if (r_pcnt >= PCW'(PENDING_DEPTH)) begin
                            r_pcnt <= '0;
                        end
                        r_key       <= r_next_seq;
                        r_for_rpt   <= 1'b1;
                        r_scan_pong <= 1'b0;
                        r_state     <= S_SEQ_CHK;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end

                S_EMIT_RTT: begin
                    if (ofree) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_RTT;
                        r_oseq   <= '0;
                        r_obase  <= r_base;
                        r_oavg   <= r_avg;
                        r_obw    <= r_bw;
                        r_obms   <= r_bms;
                        r_oams   <= r_ams;
                        r_olast  <= !r_gate;
                        if (r_gate) begin
                            if (r_pcnt >= PCW'(PENDING_DEPTH)) begin
                                r_pcnt <= '0;
                            end
                            r_key       <= r_next_seq;
                            r_for_rpt   <= 1'b1;
                            r_scan_pong <= 1'b0;
                            r_state     <= S_SEQ_CHK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end

                S_EMIT_RPT: begin
                    if (ofree) begin
                        r_ovalid   <= 1'b1;
                        r_okind    <= KIND_RPT;
                        r_oseq     <= r_key;
                        r_obase    <= r_base;
                        r_oavg     <= r_avg;
                        r_obw      <= r_bw;
                        r_obms     <= r_bms;
                        r_oams     <= r_ams;
                        r_olast    <= 1'b1;
                        r_next_seq <= r_key + 1'b1;
                        r_last_rpt <= r_now;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {2'b00, r_oams, r_obms, r_obw, r_oavg, r_obase, r_oseq};

    // queue counts never pass their depth
    a_pcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= PCW'(PENDING_DEPTH))
        else $error("pending count beyond depth");

    a_scnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scnt <= SCW'(SAMPLE_DEPTH))
        else $error("sample count beyond depth");

    // a ping is never appended to a full queue
    a_ping_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_we |-> (r_pcnt < PCW'(PENDING_DEPTH)))
        else $error("pending write into full queue");

    // divider results only arrive while the sequencer waits for them
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside wait state");

endmodule
